>>> design/sed_pkg.sv
// shared types and constants of the enumeration decision controller
`default_nettype none
package sed_pkg;

    localparam int CMD_W = 3;
    localparam int LIT_W = 12;
    localparam int LVL_W = 11;
    localparam int FL_W  = 10;

    localparam logic [LVL_W-1:0] LEVEL_MAX = 11'h7FF;
    localparam logic [LVL_W-1:0] COUNT_MAX = 11'h7FF;
    localparam logic [FL_W-1:0]  FORCE_MAX = 10'h3FF;

    typedef enum logic [CMD_W-1:0] {
        CMD_ASSIGN    = 3'd0,
        CMD_NEW_LEVEL = 3'd1,
        CMD_BACKTRACK = 3'd2,
        CMD_DECIDE    = 3'd3,
        CMD_MODEL     = 3'd4
    } cmd_t;

    typedef struct packed {
        logic signed [LIT_W-1:0] lit;
        logic [LVL_W-1:0]        lvl;
        logic                    is_dec;
    } trail_entry_t;

    function automatic logic [LIT_W-1:0] var_of(input logic signed [LIT_W-1:0] l);
        return l[LIT_W-1] ? LIT_W'(-l) : LIT_W'(l);
    endfunction

endpackage
`default_nettype wire

>>> design/sed_if.sv
// command and result channels of the enumeration decision controller
`default_nettype none
interface sed_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [sed_pkg::CMD_W-1:0]       cmd;
    logic signed [sed_pkg::LIT_W-1:0] literal;
    logic [sed_pkg::LVL_W-1:0]       target_level;

    modport source (output valid, cmd, literal, target_level, input ready);
    modport sink (input valid, cmd, literal, target_level, output ready);
endinterface

interface sed_res_if;
    logic                            valid;
    logic                            ready;
    logic signed [sed_pkg::LIT_W-1:0] decision;
    logic                            force_valid;
    logic [sed_pkg::FL_W-1:0]        force_level;
    logic                            stop_search;
    logic                            record_model;
    logic                            no_target;
    logic                            trail_full;

    modport source (output valid, decision, force_valid, force_level, stop_search,
                    record_model, no_target, trail_full, input ready);
    modport sink (input valid, decision, force_valid, force_level, stop_search,
                  record_model, no_target, trail_full, output ready);
endinterface
`default_nettype wire

>>> design/sat_enum_decision_controller.sv
// Decision controller for SAT model enumeration: one command beat in, one result beat out.
// The trail and a per-variable occupancy count live in two single-port synchronous
// memories; commands that use them run read-modify-write sequences on them, one command at a
// time. New level, unknown commands, an ignored model found, a backtrack that ends the
// search and a replayed decision touch neither memory. An assignment, unless dropped or
// ignored, writes the trail and, for a literal naming a variable, bumps that count; a
// backtrack pops trail entries one by one, lowering their counts; a decide request
// examines variables in turn for the lowest free one, after a stale backtrack first
// examining trail entries for a positive decision; model found examines trail entries
// for a positive decision from the top down.
// A result waiting on the output register stalls the finish of the next command only.
// After reset a clearing pass zeroes every occupancy entry, 0 to MAX_VARS, before
// the first command is taken.
`default_nettype none
module sat_enum_decision_controller #(
    parameter int MAX_VARS = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    sed_cmd_if.sink                       cmd_ch,
    sed_res_if.source                     res_ch,
    input  wire logic                     cfg_we,
    input  wire logic [sed_pkg::LVL_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(MAX_VARS + 1);
    localparam int SW = $clog2(MAX_VARS + 2);
    localparam int LW = sed_pkg::LIT_W;
    localparam int VW = sed_pkg::LVL_W;
    localparam int FW = sed_pkg::FL_W;

    typedef enum logic [11:0] {
        S_CLR    = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_ASN_RD = 12'b000000000100,
        S_ASN_WR = 12'b000000001000,
        S_POP0   = 12'b000000010000,
        S_POP1   = 12'b000000100000,
        S_POP2   = 12'b000001000000,
        S_FIND0  = 12'b000010000000,
        S_FIND1  = 12'b000100000000,
        S_SCAN0  = 12'b001000000000,
        S_SCAN1  = 12'b010000000000,
        S_DONE   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]        top_reg, top_next;
    logic signed [LW-1:0] top_lvl_reg, top_lvl_next;
    logic [VW-1:0]        cur_lvl_reg, cur_lvl_next;
    logic [VW-1:0]        dcnt_reg, dcnt_next;
    logic [VW-1:0]        ncnt_reg, ncnt_next;
    logic                 pend_reg, pend_next;
    logic                 done_reg, done_next;
    logic                 stale_reg, stale_next;
    logic                 rpend_reg, rpend_next;
    logic signed [LW-1:0] rlit_reg, rlit_next;
    logic [VW-1:0]        vcount_reg, vcount_next;
    logic [AW-1:0]        clr_reg, clr_next;

    logic [sed_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic signed [LW-1:0]      lit_reg, lit_next;
    logic [VW-1:0]             tgt_reg, tgt_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [SW-1:0]             scan_reg, scan_next;
    logic [AW-1:0]             popv_reg, popv_next;
    logic                      popin_reg, popin_next;

    logic signed [LW-1:0]          rdec_reg, rdec_next;
    logic                          rfv_reg, rfv_next;
    logic [sed_pkg::FL_W-1:0]      rfl_reg, rfl_next;
    logic                          rstop_reg, rstop_next;
    logic                          rrec_reg, rrec_next;
    logic                          rnt_reg, rnt_next;
    logic                          rfull_reg, rfull_next;

    logic                          ovalid_reg, ovalid_next;
    logic signed [LW-1:0]          odec_reg, odec_next;
    logic                          ofv_reg, ofv_next;
    logic [sed_pkg::FL_W-1:0]      ofl_reg, ofl_next;
    logic                          ostop_reg, ostop_next;
    logic                          orec_reg, orec_next;
    logic                          ont_reg, ont_next;
    logic                          ofull_reg, ofull_next;

    sed_pkg::trail_entry_t trail_mem [0:MAX_VARS];
    sed_pkg::trail_entry_t tr_q;
    logic                  tr_we, tr_re;
    logic [AW-1:0]         tr_waddr, tr_raddr;
    sed_pkg::trail_entry_t tr_wdata;

    logic [AW-1:0] cnt_mem [0:MAX_VARS];
    logic [AW-1:0] cnt_q;
    logic          cnt_we, cnt_re;
    logic [AW-1:0] cnt_waddr, cnt_raddr, cnt_wdata;

    logic [31:0] limit_w;
    logic [31:0] scan_w;
    logic [31:0] lit_v_w;
    logic        lit_in;
    logic [31:0] tr_v_w;
    logic        tr_in;
    logic signed [LW-1:0] dec_val;
    logic        accept;

    always_ff @(posedge clk)
    begin
        if (tr_we)
        begin
            trail_mem[tr_waddr] <= tr_wdata;
        end
        if (tr_re)
        begin
            tr_q <= trail_mem[tr_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_q <= cnt_mem[cnt_raddr];
        end
    end

    assign cmd_ch.ready = (state_reg == S_IDLE);
    assign accept       = cmd_ch.valid && cmd_ch.ready;

    assign res_ch.valid        = ovalid_reg;
    assign res_ch.decision     = odec_reg;
    assign res_ch.force_valid  = ofv_reg;
    assign res_ch.force_level  = ofl_reg;
    assign res_ch.stop_search  = ostop_reg;
    assign res_ch.record_model = orec_reg;
    assign res_ch.no_target    = ont_reg;
    assign res_ch.trail_full   = ofull_reg;

    assign limit_w = (32'(vcount_reg) < 32'(MAX_VARS)) ? 32'(vcount_reg) : 32'(MAX_VARS);
    assign scan_w  = 32'(scan_reg);
    assign lit_v_w = 32'(sed_pkg::var_of(lit_reg));
    assign lit_in  = (lit_v_w != 32'd0) && (lit_v_w <= 32'(MAX_VARS));
    assign tr_v_w  = 32'(sed_pkg::var_of(tr_q.lit));
    assign tr_in   = (tr_v_w != 32'd0) && (tr_v_w <= 32'(MAX_VARS));
    assign dec_val = pend_reg ? -LW'(scan_w[LW-1:0]) : LW'(scan_w[LW-1:0]);

    always_comb
    begin
        state_next   = state_reg;
        top_next     = top_reg;
        top_lvl_next = top_lvl_reg;
        cur_lvl_next = cur_lvl_reg;
        dcnt_next    = dcnt_reg;
        ncnt_next    = ncnt_reg;
        pend_next    = pend_reg;
        done_next    = done_reg;
        stale_next   = stale_reg;
        rpend_next   = rpend_reg;
        rlit_next    = rlit_reg;
        vcount_next  = cfg_we ? cfg_wdata : vcount_reg;
        clr_next     = clr_reg;
        cmd_next     = cmd_reg;
        lit_next     = lit_reg;
        tgt_next     = tgt_reg;
        idx_next     = idx_reg;
        scan_next    = scan_reg;
        popv_next    = popv_reg;
        popin_next   = popin_reg;
        rdec_next    = rdec_reg;
        rfv_next     = rfv_reg;
        rfl_next     = rfl_reg;
        rstop_next   = rstop_reg;
        rrec_next    = rrec_reg;
        rnt_next     = rnt_reg;
        rfull_next   = rfull_reg;
        ovalid_next  = ovalid_reg && !res_ch.ready;
        odec_next    = odec_reg;
        ofv_next     = ofv_reg;
        ofl_next     = ofl_reg;
        ostop_next   = ostop_reg;
        orec_next    = orec_reg;
        ont_next     = ont_reg;
        ofull_next   = ofull_reg;

        tr_we     = 1'b0;
        tr_waddr  = '0;
        tr_wdata  = '0;
        tr_re     = 1'b0;
        tr_raddr  = '0;
        cnt_we    = 1'b0;
        cnt_waddr = '0;
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = '0;

        case (state_reg)
            S_CLR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (32'(clr_reg) == 32'(MAX_VARS))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd_ch.cmd;
                    lit_next   = cmd_ch.literal;
                    tgt_next   = cmd_ch.target_level;
                    rdec_next  = '0;
                    rfv_next   = 1'b0;
                    rfl_next   = '0;
                    rstop_next = 1'b0;
                    rrec_next  = 1'b0;
                    rnt_next   = 1'b0;
                    rfull_next = 1'b0;
                    state_next = S_DONE;
                    case (cmd_ch.cmd)
                        sed_pkg::CMD_ASSIGN:
                        begin
                            if (!done_reg)
                            begin
                                if (32'(top_reg) >= 32'(MAX_VARS))
                                begin
                                    rfull_next = 1'b1;
                                end
                                else
                                begin
                                    tr_we           = 1'b1;
                                    tr_waddr        = top_reg + AW'(1);
                                    tr_wdata.lit    = cmd_ch.literal;
                                    tr_wdata.lvl    = cur_lvl_reg;
                                    tr_wdata.is_dec = (top_lvl_reg < $signed({1'b0, cur_lvl_reg}))
                                                      && (cur_lvl_reg != '0);
                                    top_next        = top_reg + AW'(1);
                                    top_lvl_next    = $signed({1'b0, cur_lvl_reg});
                                    state_next      = S_ASN_RD;
                                end
                            end
                        end
                        sed_pkg::CMD_NEW_LEVEL:
                        begin
                            if (cur_lvl_reg != sed_pkg::LEVEL_MAX)
                            begin
                                cur_lvl_next = cur_lvl_reg + VW'(1);
                            end
                        end
                        sed_pkg::CMD_BACKTRACK:
                        begin
                            if (dcnt_reg == ncnt_reg)
                            begin
                                rstop_next = 1'b1;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                stale_next = ($signed({1'b0, cur_lvl_reg}) != top_lvl_reg);
                                state_next = S_POP0;
                            end
                        end
                        sed_pkg::CMD_DECIDE:
                        begin
                            if (rpend_reg)
                            begin
                                rpend_next = 1'b0;
                                rdec_next  = rlit_reg;
                                rlit_next  = '0;
                            end
                            else if (stale_reg)
                            begin
                                stale_next = 1'b0;
                                idx_next   = top_reg;
                                state_next = S_FIND0;
                            end
                            else
                            begin
                                scan_next  = SW'(1);
                                state_next = S_SCAN0;
                            end
                        end
                        sed_pkg::CMD_MODEL:
                        begin
                            if (!done_reg)
                            begin
                                rrec_next  = !stale_reg;
                                idx_next   = top_reg;
                                state_next = S_FIND0;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ASN_RD:
            begin
                if (lit_in)
                begin
                    cnt_re     = 1'b1;
                    cnt_raddr  = lit_v_w[AW-1:0];
                    state_next = S_ASN_WR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ASN_WR:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = lit_v_w[AW-1:0];
                cnt_wdata  = cnt_q + AW'(1);
                state_next = S_DONE;
            end
            S_POP0:
            begin
                if ((top_reg != '0) && (top_lvl_reg > $signed({1'b0, tgt_reg})))
                begin
                    tr_re      = 1'b1;
                    tr_raddr   = top_reg;
                    state_next = S_POP1;
                end
                else
                begin
                    cur_lvl_next = tgt_reg;
                    state_next   = S_DONE;
                end
            end
            S_POP1:
            begin
                if (tr_q.is_dec && (dcnt_reg != '0))
                begin
                    dcnt_next = dcnt_reg - VW'(1);
                end
                popv_next  = tr_v_w[AW-1:0];
                popin_next = tr_in;
                cnt_re     = tr_in;
                cnt_raddr  = tr_v_w[AW-1:0];
                tr_re      = 1'b1;
                tr_raddr   = top_reg - AW'(1);
                top_next   = top_reg - AW'(1);
                state_next = S_POP2;
            end
            S_POP2:
            begin
                top_lvl_next = (top_reg == '0) ? LW'(-1) : $signed({1'b0, tr_q.lvl});
                if (popin_reg)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = popv_reg;
                    cnt_wdata = cnt_q - AW'(1);
                end
                state_next = S_POP0;
            end
            S_FIND0:
            begin
                if (idx_reg == '0)
                begin
                    rnt_next = 1'b1;
                    if (cmd_reg == sed_pkg::CMD_DECIDE)
                    begin
                        scan_next  = SW'(1);
                        state_next = S_SCAN0;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    tr_re      = 1'b1;
                    tr_raddr   = idx_reg;
                    state_next = S_FIND1;
                end
            end
            S_FIND1:
            begin
                if (tr_q.is_dec && !tr_q.lit[LW-1] && (tr_q.lit != '0))
                begin
                    rfv_next  = 1'b1;
                    pend_next = 1'b1;
                    if (tr_q.lvl == '0)
                    begin
                        rfl_next = '0;
                    end
                    else if (tr_q.lvl > VW'(1024))
                    begin
                        rfl_next = sed_pkg::FORCE_MAX;
                    end
                    else
                    begin
                        rfl_next = FW'(tr_q.lvl - VW'(1));
                    end
                    if (cmd_reg == sed_pkg::CMD_DECIDE)
                    begin
                        rpend_next = 1'b1;
                        scan_next  = SW'(1);
                        state_next = S_SCAN0;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg - AW'(1);
                    state_next = S_FIND0;
                end
            end
            S_SCAN0:
            begin
                if (scan_w > limit_w)
                begin
                    rdec_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_re     = 1'b1;
                    cnt_raddr  = scan_w[AW-1:0];
                    state_next = S_SCAN1;
                end
            end
            S_SCAN1:
            begin
                if (cnt_q == '0)
                begin
                    rdec_next = dec_val;
                    if (pend_reg)
                    begin
                        pend_next = 1'b0;
                        if ((dcnt_reg == ncnt_reg) && (ncnt_reg != sed_pkg::COUNT_MAX))
                        begin
                            ncnt_next = ncnt_reg + VW'(1);
                        end
                    end
                    if (dcnt_reg != sed_pkg::COUNT_MAX)
                    begin
                        dcnt_next = dcnt_reg + VW'(1);
                    end
                    if (rpend_reg)
                    begin
                        rlit_next = dec_val;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    scan_next  = scan_reg + SW'(1);
                    state_next = S_SCAN0;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || res_ch.ready)
                begin
                    ovalid_next = 1'b1;
                    odec_next   = rdec_reg;
                    ofv_next    = rfv_reg;
                    ofl_next    = rfl_reg;
                    ostop_next  = rstop_reg;
                    orec_next   = rrec_reg;
                    ont_next    = rnt_reg;
                    ofull_next  = rfull_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            top_reg     <= '0;
            top_lvl_reg <= LW'(-1);
            cur_lvl_reg <= '0;
            dcnt_reg    <= '0;
            ncnt_reg    <= '0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
            stale_reg   <= 1'b0;
            rpend_reg   <= 1'b0;
            rlit_reg    <= '0;
            vcount_reg  <= VW'(1024);
            clr_reg     <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            top_lvl_reg <= top_lvl_next;
            cur_lvl_reg <= cur_lvl_next;
            dcnt_reg    <= dcnt_next;
            ncnt_reg    <= ncnt_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
            stale_reg   <= stale_next;
            rpend_reg   <= rpend_next;
            rlit_reg    <= rlit_next;
            vcount_reg  <= vcount_next;
            clr_reg     <= clr_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        lit_reg   <= lit_next;
        tgt_reg   <= tgt_next;
        idx_reg   <= idx_next;
        scan_reg  <= scan_next;
        popv_reg  <= popv_next;
        popin_reg <= popin_next;
        rdec_reg  <= rdec_next;
        rfv_reg   <= rfv_next;
        rfl_reg   <= rfl_next;
        rstop_reg <= rstop_next;
        rrec_reg  <= rrec_next;
        rnt_reg   <= rnt_next;
        rfull_reg <= rfull_next;
        odec_reg  <= odec_next;
        ofv_reg   <= ofv_next;
        ofl_reg   <= ofl_next;
        ostop_reg <= ostop_next;
        orec_reg  <= orec_next;
        ont_reg   <= ont_next;
        ofull_reg <= ofull_next;
    end

endmodule
`default_nettype wire

>>> verif/tb_sat_enum_decision_controller.sv
// testbench for the enumeration decision controller: predictor scoreboard, drivers, checks
`default_nettype none
module tb_sat_enum_decision_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = 1024;
    localparam int WDOG_MAX  = 60000;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic signed [sed_pkg::LIT_W-1:0] decision;
        logic                             force_valid;
        logic [sed_pkg::FL_W-1:0]         force_level;
        logic                             stop_search;
        logic                             record_model;
        logic                             no_target;
        logic                             trail_full;
    } verdict_t;

    class decision_scoreboard;
        int       lit_at[DEPTH+1];
        int       lvl_at[DEPTH+1];
        bit       dec_at[DEPTH+1];
        int       occupancy[DEPTH+1];
        int       top;
        int       level;
        int       dec_cnt;
        int       neg_cnt;
        bit       want_negative;
        bit       finished;
        bit       stale;
        bit       replay_armed;
        int       replay_val;
        int       var_limit;
        verdict_t awaited[$];
        verdict_t latest;
        int       mismatches;

        function new();
            foreach (occupancy[i])
                occupancy[i] = 0;
            lit_at[0] = 0;
            lvl_at[0] = -1;
            dec_at[0] = 0;
            top = 0;
            level = 0;
            dec_cnt = 0;
            neg_cnt = 0;
            want_negative = 0;
            finished = 0;
            stale = 0;
            replay_armed = 0;
            replay_val = 0;
            var_limit = 1024;
            mismatches = 0;
        endfunction

        function int var_num(int l);
            return l < 0 ? -l : l;
        endfunction

        function void drop_top();
            int v;
            v = var_num(lit_at[top]);
            if (dec_at[top] && dec_cnt > 0)
                dec_cnt--;
            top--;
            if (v >= 1 && v <= DEPTH)
                occupancy[v]--;
        endfunction

        function int highest_positive();
            for (int i = top; i > 0; i--)
                if (dec_at[i] && lit_at[i] > 0)
                    return i;
            return 0;
        endfunction

        function int lowest_free();
            int lim;
            lim = var_limit < DEPTH ? var_limit : DEPTH;
            for (int c = 1; c <= lim; c++)
                if (occupancy[c] == 0)
                    return c;
            return 0;
        endfunction

        function int backjump_level(int idx);
            int l;
            l = lvl_at[idx] - 1;
            if (l < 0)
                l = 0;
            if (l > 1023)
                l = 1023;
            return l;
        endfunction

        function void note_command(logic [sed_pkg::CMD_W-1:0] op,
                                   logic signed [sed_pkg::LIT_W-1:0] lit_in,
                                   logic [sed_pkg::LVL_W-1:0] tgt_in);
            verdict_t r;
            int lit, tgt, idx, v, d;
            bit is_dec;
            r = '0;
            lit = int'(lit_in);
            tgt = int'(tgt_in);
            d = 0;
            if (op == sed_pkg::CMD_ASSIGN) begin
                if (!finished) begin
                    if (top >= DEPTH) begin
                        r.trail_full = 1;
                    end else begin
                        is_dec = lvl_at[top] < level && level > 0;
                        top++;
                        lit_at[top] = lit;
                        lvl_at[top] = level;
                        dec_at[top] = is_dec;
                        v = var_num(lit);
                        if (v >= 1 && v <= DEPTH)
                            occupancy[v]++;
                    end
                end
            end else if (op == sed_pkg::CMD_NEW_LEVEL) begin
                if (level < int'(sed_pkg::LEVEL_MAX))
                    level++;
            end else if (op == sed_pkg::CMD_BACKTRACK) begin
                if (dec_cnt == neg_cnt) begin
                    r.stop_search = 1;
                    finished = 1;
                end else begin
                    stale = level != lvl_at[top];
                    while (top > 0 && lvl_at[top] > tgt)
                        drop_top();
                    level = tgt;
                end
            end else if (op == sed_pkg::CMD_DECIDE) begin
                if (replay_armed) begin
                    replay_armed = 0;
                    d = replay_val;
                    replay_val = 0;
                end else begin
                    if (stale) begin
                        stale = 0;
                        idx = highest_positive();
                        if (idx == 0) begin
                            r.no_target = 1;
                        end else begin
                            r.force_valid = 1;
                            r.force_level = sed_pkg::FL_W'(backjump_level(idx));
                            want_negative = 1;
                            replay_armed = 1;
                        end
                    end
                    v = lowest_free();
                    if (v != 0) begin
                        if (want_negative) begin
                            want_negative = 0;
                            d = -v;
                            if (dec_cnt == neg_cnt && neg_cnt < int'(sed_pkg::COUNT_MAX))
                                neg_cnt++;
                        end else begin
                            d = v;
                        end
                        if (dec_cnt < int'(sed_pkg::COUNT_MAX))
                            dec_cnt++;
                        if (replay_armed)
                            replay_val = d;
                    end
                end
            end else if (op == sed_pkg::CMD_MODEL) begin
                if (!finished) begin
                    r.record_model = !stale;
                    idx = highest_positive();
                    if (idx == 0) begin
                        r.no_target = 1;
                    end else begin
                        r.force_valid = 1;
                        r.force_level = sed_pkg::FL_W'(backjump_level(idx));
                        want_negative = 1;
                    end
                end
            end
            r.decision = sed_pkg::LIT_W'(d);
            latest = r;
            awaited = {awaited, r};
        endfunction

        function void check_verdict(verdict_t got);
            verdict_t exp_r;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("ERROR: result beat with nothing pending: %p", got);
                return;
            end
            exp_r = awaited.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("ERROR: result mismatch expected %p actual %p", exp_r, got);
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [sed_pkg::LVL_W-1:0]   cfg_wdata;
    sed_cmd_if                   cmd_ch();
    sed_res_if                   res_ch();
    decision_scoreboard          sb;
    int                          send_idle;
    int                          recv_idle;
    int                          sent;
    int                          quiet_cycles;

    sat_enum_decision_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_ch),
        .res_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // result side: check accepted beats, randomize ready
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_verdict({res_ch.decision, res_ch.force_valid, res_ch.force_level,
                              res_ch.stop_search, res_ch.record_model, res_ch.no_target,
                              res_ch.trail_full});
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send(logic [sed_pkg::CMD_W-1:0] op, logic signed [sed_pkg::LIT_W-1:0] lit,
                        logic [sed_pkg::LVL_W-1:0] tgt);
        if ($urandom_range(0, 99) < send_idle) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.cmd          <= op;
        cmd_ch.literal      <= lit;
        cmd_ch.target_level <= tgt;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sb.note_command(op, lit, tgt);
        sent++;
    endtask

    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_var_count(logic [sed_pkg::LVL_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.var_limit = int'(value);
    endtask

    // backtrack only when it cannot end the enumeration
    task automatic safe_backtrack(int tgt);
        if (sb.dec_cnt != sb.neg_cnt)
            send(sed_pkg::CMD_BACKTRACK, '0, sed_pkg::LVL_W'(tgt));
    endtask

    task automatic search_phase(int count);
        int stop_at, lim, k, raw;
        logic [sed_pkg::CMD_W-1:0] op;
        stop_at = sent + count;
        while (sent < stop_at) begin
            lim = sb.var_limit < DEPTH ? sb.var_limit : DEPTH;
            if (lim < 1)
                lim = 1;
            if (sb.level < 30 && $urandom_range(0, 3) != 0) begin
                send(sed_pkg::CMD_NEW_LEVEL, '0, '0);
                send(sed_pkg::CMD_DECIDE, '0, '0);
                if (sb.latest.decision != 0)
                    send(sed_pkg::CMD_ASSIGN, sb.latest.decision, '0);
            end
            k = $urandom_range(0, 3);
            repeat (k)
                send(sed_pkg::CMD_ASSIGN,
                     sed_pkg::LIT_W'($urandom_range(0, 1) ? $urandom_range(1, lim)
                                                         : -$urandom_range(1, lim)), '0);
            if ($urandom_range(0, 5) == 0) begin
                send(sed_pkg::CMD_MODEL, '0, '0);
                if (sb.latest.force_valid)
                    safe_backtrack(int'(sb.latest.force_level));
            end
            if ($urandom_range(0, 4) == 0)
                safe_backtrack($urandom_range(0, sb.level));
            if (sb.top > 150)
                safe_backtrack(0);
            if ($urandom_range(0, 11) == 0) begin
                op  = sed_pkg::CMD_W'($urandom_range(0, 7));
                raw = $urandom_range(0, 4095);
                if (op == sed_pkg::CMD_BACKTRACK && sb.dec_cnt == sb.neg_cnt)
                    op = sed_pkg::CMD_DECIDE;
                send(op, sed_pkg::LIT_W'(raw), sed_pkg::LVL_W'($urandom_range(0, 2047)));
            end
        end
    endtask

    initial begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.cmd          = '0;
        cmd_ch.literal      = '0;
        cmd_ch.target_level = '0;
        res_ch.ready        = 1'b0;
        quiet_cycles        = 0;
        sent                = 0;
        send_idle           = 9;
        recv_idle           = 72;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening
        write_var_count(11'd3);
        send(sed_pkg::CMD_DECIDE, '0, '0);
        send(sed_pkg::CMD_NEW_LEVEL, '0, '0);
        send(sed_pkg::CMD_ASSIGN, 12'sd1, '0);
        send(sed_pkg::CMD_ASSIGN, 12'h800, '0);
        send(sed_pkg::CMD_ASSIGN, 12'sd0, '0);
        send(sed_pkg::CMD_ASSIGN, 12'h7FF, '0);
        send(sed_pkg::CMD_ASSIGN, 12'sd1024, '0);
        send(sed_pkg::CMD_ASSIGN, -12'sd1024, '0);
        send(sed_pkg::CMD_MODEL, '0, '0);
        send(3'd5, 12'hFFF, 11'h7FF);
        send(3'd6, '0, '0);
        send(3'd7, 12'h555, 11'h2AA);
        send(sed_pkg::CMD_NEW_LEVEL, '0, '0);
        send(sed_pkg::CMD_DECIDE, '0, '0);
        send(sed_pkg::CMD_ASSIGN, -12'sd2, '0);
        send(sed_pkg::CMD_ASSIGN, 12'sd2, '0);
        send(sed_pkg::CMD_NEW_LEVEL, '0, '0);
        send(sed_pkg::CMD_DECIDE, '0, '0);
        send(sed_pkg::CMD_ASSIGN, 12'sd3, '0);
        send(sed_pkg::CMD_DECIDE, '0, '0);
        send(sed_pkg::CMD_NEW_LEVEL, '0, '0);
        safe_backtrack(1);
        send(sed_pkg::CMD_DECIDE, '0, '0);
        send(sed_pkg::CMD_DECIDE, '0, '0);
        send(sed_pkg::CMD_MODEL, '0, '0);
        safe_backtrack(2047);
        send(sed_pkg::CMD_NEW_LEVEL, '0, '0);
        safe_backtrack(0);
        wait_idle();

        write_var_count(11'h7FF);
        search_phase(180);
        wait_idle();
        send_idle = 72;
        recv_idle = 9;
        write_var_count(sed_pkg::LVL_W'($urandom_range(2, 40)));
        search_phase(180);
        wait_idle();
        send_idle = 0;
        recv_idle = 0;
        write_var_count(11'd1);
        search_phase(90);
        wait_idle();
        write_var_count(sed_pkg::LVL_W'($urandom_range(1, 1024)));
        search_phase(90);
        wait_idle();

        // zero variables, then fill the trail past its end above level 0
        write_var_count(11'd0);
        send(sed_pkg::CMD_DECIDE, '0, '0);
        send(sed_pkg::CMD_MODEL, '0, '0);
        send(sed_pkg::CMD_NEW_LEVEL, '0, '0);
        while (sb.top < DEPTH)
            send(sed_pkg::CMD_ASSIGN, '0, '0);
        repeat (3)
            send(sed_pkg::CMD_ASSIGN, 12'sd5, '0);
        wait_idle();

        // bring the counts level, then the final backtrack ends the search
        write_var_count(11'd1024);
        for (int n = 0; n < 60 && sb.dec_cnt != sb.neg_cnt; n++) begin
            if (sb.dec_cnt < sb.neg_cnt) begin
                send(sed_pkg::CMD_DECIDE, '0, '0);
            end else begin
                send(sed_pkg::CMD_NEW_LEVEL, '0, '0);
                send(sed_pkg::CMD_ASSIGN, '0, '0);
                send(sed_pkg::CMD_BACKTRACK, '0, '0);
            end
        end
        send(sed_pkg::CMD_BACKTRACK, '0, '0);
        send(sed_pkg::CMD_ASSIGN, 12'sd7, '0);
        send(sed_pkg::CMD_MODEL, '0, '0);
        send(sed_pkg::CMD_NEW_LEVEL, '0, '0);
        send(sed_pkg::CMD_DECIDE, '0, '0);
        send(sed_pkg::CMD_BACKTRACK, '0, '0);
        wait_idle();
        repeat (50) @(posedge clk);

        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> sat_enum_decision_controller.f
design/sed_pkg.sv
design/sed_if.sv
design/sat_enum_decision_controller.sv
verif/tb_sat_enum_decision_controller.sv
